FILE: hw/rtl/lltpe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lltpe_pkg: shared types and constants
// Symbol markers, table actions, result codes, sequencer states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lltpe_pkg;

	localparam logic [1:0]  FUNC_TOKEN = 2'd0;
	localparam logic [1:0]  FUNC_TABLE = 2'd1;
	localparam logic [1:0]  FUNC_RULE  = 2'd2;

	localparam logic [10:0] SYM_BOTTOM = 11'd999;
	localparam logic [10:0] SYM_SYNC   = 11'd777;
	localparam logic [9:0]  ACT_SYNC   = 10'd777;
	localparam logic [9:0]  ACT_SKIP   = 10'd888;

	localparam logic [2:0]  RES_MATCH  = 3'd0;
	localparam logic [2:0]  RES_TSKIP  = 3'd1;
	localparam logic [2:0]  RES_FSKIP  = 3'd2;
	localparam logic [2:0]  RES_END    = 3'd3;
	localparam logic [2:0]  RES_LOAD   = 3'd4;
	localparam logic [2:0]  RES_OVER   = 3'd5;
	localparam logic [2:0]  RES_LIMIT  = 3'd6;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_CHECK,
		S_TOP,
		S_ACT,
		S_SCAN,
		S_SCHK,
		S_FIT,
		S_PUSH,
		S_PWR,
		S_EMRD,
		S_EMIT
	} lltpe_state_t;

	typedef struct packed {
		logic       take;
		logic       load_wr;
		logic       stk_rd;
		logic       step_inc;
		logic       tbl_rd;
		logic       pop;
		logic       scan_start;
		logic       scan_rd;
		logic       scan_next;
		logic       fit;
		logic       push_rd;
		logic       push_wr;
		logic       set_res;
		logic [2:0] res;
		logic       out_load;
	} lltpe_cmd_t;

	typedef struct packed {
		logic is_token;
		logic sp_zero;
		logic steps_done;
		logic top_bottom;
		logic top_match;
		logic top_sync;
		logic top_neg;
		logic act_sync;
		logic act_skip;
		logic rule_ok;
		logic scan_end;
		logic fits;
		logic len_zero;
		logic push_last;
		logic out_busy;
	} lltpe_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lltpe_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lltpe_ctrl: parse sequencer
// Walks each item through load, stack examination, table lookup, rule
// scan, push and result phases by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module lltpe_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire lltpe_pkg::lltpe_stat_t stat,
	output lltpe_pkg::lltpe_cmd_t       cmd
);
	import lltpe_pkg::*;

	lltpe_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DISP;
			end
			S_DISP: begin
				state_d = stat.is_token ? S_CHECK : S_EMRD;
			end
			S_CHECK: begin
				if (stat.sp_zero || stat.steps_done) state_d = S_EMRD;
				else state_d = S_TOP;
			end
			S_TOP: begin
				if (stat.top_bottom || stat.top_match) state_d = S_EMRD;
				else if (stat.top_sync) state_d = S_CHECK;
				else state_d = S_ACT;
			end
			S_ACT: begin
				if (stat.act_sync) state_d = S_CHECK;
				else if (stat.act_skip || !stat.top_neg) state_d = S_EMRD;
				else if (stat.rule_ok) state_d = S_SCAN;
				else state_d = S_CHECK;
			end
			S_SCAN: begin
				state_d = S_SCHK;
			end
			S_SCHK: begin
				state_d = stat.scan_end ? S_FIT : S_SCAN;
			end
			S_FIT: begin
				if (!stat.fits) state_d = S_EMRD;
				else if (stat.len_zero) state_d = S_CHECK;
				else state_d = S_PUSH;
			end
			S_PUSH: begin
				state_d = S_PWR;
			end
			S_PWR: begin
				state_d = stat.push_last ? S_CHECK : S_PUSH;
			end
			S_EMRD: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (!stat.out_busy) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				cmd.take = in_valid;
			end
			S_DISP: begin
				if (!stat.is_token) begin
					cmd.load_wr = 1'b1;
					cmd.set_res = 1'b1;
					cmd.res     = RES_LOAD;
				end
			end
			S_CHECK: begin
				if (stat.steps_done) begin
					cmd.set_res = 1'b1;
					cmd.res     = RES_LIMIT;
				end else if (stat.sp_zero) begin
					cmd.set_res = 1'b1;
					cmd.res     = RES_END;
				end else begin
					cmd.stk_rd = 1'b1;
				end
			end
			S_TOP: begin
				cmd.step_inc = 1'b1;
				cmd.tbl_rd   = 1'b1;
				if (stat.top_bottom) begin
					cmd.set_res = 1'b1;
					cmd.res     = RES_END;
				end else if (stat.top_match) begin
					cmd.pop     = 1'b1;
					cmd.set_res = 1'b1;
					cmd.res     = RES_MATCH;
				end else if (stat.top_sync) begin
					cmd.pop = 1'b1;
				end
			end
			S_ACT: begin
				if (stat.act_sync) begin
					cmd.pop = 1'b1;
				end else if (stat.act_skip) begin
					cmd.set_res = 1'b1;
					cmd.res     = RES_TSKIP;
				end else if (!stat.top_neg) begin
					cmd.set_res = 1'b1;
					cmd.res     = RES_FSKIP;
				end else if (stat.rule_ok) begin
					cmd.scan_start = 1'b1;
				end else begin
					cmd.pop = 1'b1;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
			end
			S_SCHK: begin
				cmd.scan_next = 1'b1;
			end
			S_FIT: begin
				if (!stat.fits) begin
					cmd.set_res = 1'b1;
					cmd.res     = RES_OVER;
				end else begin
					cmd.fit = 1'b1;
				end
			end
			S_PUSH: begin
				cmd.push_rd = 1'b1;
			end
			S_PWR: begin
				cmd.push_wr = 1'b1;
			end
			S_EMRD: begin
				cmd.stk_rd = 1'b1;
			end
			S_EMIT: begin
				cmd.out_load = !stat.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: hw/rtl/lltpe_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lltpe_dp: parser datapath
// Holds the symbol stack, parse table and rule book memories, the stack
// pointer, step counter, rule scan/push counters and the result register.
// ----------------------------------------------------------------------------
module lltpe_dp #(
	parameter int NT_ROWS     = 32,
	parameter int TERMINALS   = 64,
	parameter int RULES       = 64,
	parameter int RULE_LEN    = 10,
	parameter int STACK_DEPTH = 64,
	parameter int MAX_STEPS   = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lltpe_pkg::lltpe_cmd_t cmd,
	output lltpe_pkg::lltpe_stat_t  stat,
	input  wire logic [1:0]         func,
	input  wire logic [5:0]         token_code,
	input  wire logic [4:0]         table_row,
	input  wire logic [5:0]         table_col,
	input  wire logic [5:0]         rule_number,
	input  wire logic [3:0]         rule_slot,
	input  wire logic signed [10:0] entry_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              status,
	output logic signed [10:0]      top_symbol,
	output logic [6:0]              stack_level
);
	import lltpe_pkg::*;

	localparam int TBL_N  = NT_ROWS * TERMINALS;
	localparam int PR_N   = RULES * RULE_LEN;
	localparam int SP_W   = $clog2(STACK_DEPTH + 1);
	localparam int SA_W   = $clog2(STACK_DEPTH);
	localparam int TA_W   = $clog2(TBL_N);
	localparam int PA_W   = $clog2(PR_N);
	localparam int LEN_W  = $clog2(RULE_LEN + 1);
	localparam int STEP_W = $clog2(MAX_STEPS + 1);
	localparam int ROW_W  = $clog2(NT_ROWS);

	logic [10:0]      stk_sym_mem [STACK_DEPTH];
	logic [ROW_W-1:0] stk_tag_mem [STACK_DEPTH];
	logic [9:0]       tbl_mem [TBL_N];
	logic [10:0]      prod_mem [PR_N];

	logic [1:0]       func_q;
	logic [5:0]       tok_q;
	logic [4:0]       trow_q;
	logic [5:0]       tcol_q;
	logic [5:0]       rnum_q;
	logic [3:0]       rslot_q;
	logic [10:0]      val_q;

	logic [SP_W-1:0]   sp_q;
	logic [STEP_W-1:0] steps_q;
	logic              w0_q, w1_q;
	logic              rd0_q, rd1_q;
	logic [10:0]       stk_sym_rd_q;
	logic [ROW_W-1:0]  stk_tag_rd_q;
	logic [9:0]        tbl_rd_q;
	logic              oor_q;
	logic [ROW_W-1:0]  row_q;
	logic [PA_W-1:0]   base_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  idx_q;
	logic [SA_W-1:0]   wp_q;
	logic [10:0]       prod_rd_q;
	logic [2:0]        res_q;
	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [10:0]       top_q;
	logic [6:0]        level_q;

	logic [SA_W-1:0]   top_addr;
	logic [10:0]       top_sym;
	logic [ROW_W-1:0]  top_tag;
	logic              top_neg;
	logic [11:0]       neg_row;
	logic [ROW_W-1:0]  look_row;
	logic              look_ok;
	logic [TA_W-1:0]   look_addr;
	logic [TA_W-1:0]   ld_taddr;
	logic [PA_W-1:0]   ld_paddr;
	logic [9:0]        act;
	logic [PA_W-1:0]   scan_addr;
	logic [PA_W-1:0]   push_addr;
	logic [SP_W-1:0]   sp_new;
	logic [SP_W+6:0]   level_ext;

	assign top_addr  = SA_W'(32'(sp_q) - 32'd1);
	assign top_sym   = (rd0_q && !w0_q) ? SYM_BOTTOM :
	                   (rd1_q && !w1_q) ? 11'h7FF : stk_sym_rd_q;
	assign top_tag   = (rd0_q && !w0_q) ? '0 :
	                   (rd1_q && !w1_q) ? ROW_W'(1) : stk_tag_rd_q;
	assign top_neg   = top_sym[10];
	assign neg_row   = 12'd0 - {top_sym[10], top_sym};
	assign look_row  = top_neg ? neg_row[ROW_W-1:0] : top_tag;
	assign look_ok   = (top_neg ? (32'(neg_row) < NT_ROWS) : (32'(top_tag) < NT_ROWS)) &&
	                   (32'(tok_q) < TERMINALS);
	assign look_addr = TA_W'(32'(look_row) * TERMINALS + 32'(tok_q));
	assign ld_taddr  = TA_W'(32'(trow_q) * TERMINALS + 32'(tcol_q));
	assign ld_paddr  = PA_W'(32'(rnum_q) * RULE_LEN + 32'(rslot_q));
	assign act       = oor_q ? ACT_SKIP : tbl_rd_q;
	assign scan_addr = PA_W'(32'(base_q) + 32'(len_q));
	assign push_addr = PA_W'(32'(base_q) + 32'(idx_q) - 32'd1);
	assign sp_new    = SP_W'(32'(sp_q) - 32'd1 + 32'(len_q));
	assign level_ext = {7'd0, sp_q};

	always_comb begin
		stat            = '0;
		stat.is_token   = (func_q == FUNC_TOKEN);
		stat.sp_zero    = (sp_q == '0);
		stat.steps_done = (32'(steps_q) == MAX_STEPS);
		stat.top_bottom = (top_sym == SYM_BOTTOM);
		stat.top_match  = (top_sym == {5'd0, tok_q});
		stat.top_sync   = (top_sym == SYM_SYNC);
		stat.top_neg    = top_neg;
		stat.act_sync   = (act == ACT_SYNC);
		stat.act_skip   = (act == ACT_SKIP);
		stat.rule_ok    = (32'(act) < RULES);
		stat.scan_end   = (prod_rd_q == SYM_BOTTOM) || (32'(len_q) + 32'd1 == RULE_LEN);
		stat.fits       = (32'(sp_q) - 32'd1 + 32'(len_q) <= STACK_DEPTH);
		stat.len_zero   = (len_q == '0);
		stat.push_last  = (idx_q == LEN_W'(1));
		stat.out_busy   = out_valid_q && out_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			func_q  <= func;
			tok_q   <= token_code;
			trow_q  <= table_row;
			tcol_q  <= table_col;
			rnum_q  <= rule_number;
			rslot_q <= rule_slot;
			val_q   <= entry_value;
		end
		if (cmd.load_wr && func_q == FUNC_TABLE &&
		    32'(trow_q) < NT_ROWS && 32'(tcol_q) < TERMINALS) begin
			tbl_mem[ld_taddr] <= val_q[9:0];
		end
		if (cmd.load_wr && func_q == FUNC_RULE &&
		    32'(rnum_q) < RULES && 32'(rslot_q) < RULE_LEN) begin
			prod_mem[ld_paddr] <= val_q;
		end
		if (cmd.tbl_rd) begin
			tbl_rd_q <= tbl_mem[look_addr];
			oor_q    <= !look_ok;
			row_q    <= look_row;
		end
		if (cmd.scan_rd) begin
			prod_rd_q <= prod_mem[scan_addr];
		end else if (cmd.push_rd) begin
			prod_rd_q <= prod_mem[push_addr];
		end
		if (cmd.stk_rd) begin
			stk_sym_rd_q <= stk_sym_mem[top_addr];
			stk_tag_rd_q <= stk_tag_mem[top_addr];
			rd0_q        <= (top_addr == '0);
			rd1_q        <= (top_addr == SA_W'(1));
		end
		if (cmd.push_wr) begin
			stk_sym_mem[wp_q] <= prod_rd_q;
			stk_tag_mem[wp_q] <= row_q;
		end
		if (cmd.scan_start) begin
			base_q <= PA_W'(32'(act) * RULE_LEN);
			len_q  <= '0;
		end else if (cmd.scan_next && prod_rd_q != SYM_BOTTOM) begin
			len_q <= len_q + LEN_W'(1);
		end
		if (cmd.fit) begin
			wp_q  <= top_addr;
			idx_q <= len_q;
		end else if (cmd.push_wr) begin
			wp_q  <= wp_q + SA_W'(1);
			idx_q <= idx_q - LEN_W'(1);
		end
		if (cmd.set_res) begin
			res_q <= cmd.res;
		end
		if (cmd.out_load) begin
			status_q <= res_q;
			top_q    <= (sp_q == '0) ? 11'd0 : top_sym;
			level_q  <= level_ext[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= SP_W'(2);
			steps_q     <= '0;
			w0_q        <= 1'b0;
			w1_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				steps_q <= '0;
			end else if (cmd.step_inc) begin
				steps_q <= steps_q + STEP_W'(1);
			end
			if (cmd.pop) begin
				sp_q <= sp_q - SP_W'(1);
			end else if (cmd.fit) begin
				sp_q <= sp_new;
			end
			if (cmd.push_wr && wp_q == '0) w0_q <= 1'b1;
			if (cmd.push_wr && wp_q == SA_W'(1)) w1_q <= 1'b1;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign top_symbol  = top_q;
	assign stack_level = level_q;

endmodule
`default_nettype wire

FILE: hw/rtl/ll1_table_parser_engine_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ll1_table_parser_engine_top: table-driven LL(1) parser with recovery
// Load items fill the parse table and rule book; token items run the
// stack loop against them and report one result each.
// ----------------------------------------------------------------------------
// Load item: the entry is written, then the result is reported once the output is free.
// Token item: stack examination, table lookup, rule scan and push repeat until a result
//   or the step limit; one item at a time, set by the single-port memories walked by
//   the sequencer.
// Reset: stack holds bottom marker and start nonterminal (level 2); table
//   and rule book contents stay undefined until written.
module ll1_table_parser_engine_top #(
	parameter int NT_ROWS     = 32,
	parameter int TERMINALS   = 64,
	parameter int RULES       = 64,
	parameter int RULE_LEN    = 10,
	parameter int STACK_DEPTH = 64,
	parameter int MAX_STEPS   = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         func,
	input  wire logic [5:0]         token_code,
	input  wire logic [4:0]         table_row,
	input  wire logic [5:0]         table_col,
	input  wire logic [5:0]         rule_number,
	input  wire logic [3:0]         rule_slot,
	input  wire logic signed [10:0] entry_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              status,
	output logic signed [10:0]      top_symbol,
	output logic [6:0]              stack_level
);
	import lltpe_pkg::*;

	lltpe_cmd_t  cmd;
	lltpe_stat_t stat;

	lltpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	lltpe_dp #(
		.NT_ROWS     (NT_ROWS),
		.TERMINALS   (TERMINALS),
		.RULES       (RULES),
		.RULE_LEN    (RULE_LEN),
		.STACK_DEPTH (STACK_DEPTH),
		.MAX_STEPS   (MAX_STEPS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.func        (func),
		.token_code  (token_code),
		.table_row   (table_row),
		.table_col   (table_col),
		.rule_number (rule_number),
		.rule_slot   (rule_slot),
		.entry_value (entry_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.top_symbol  (top_symbol),
		.stack_level (stack_level)
	);

endmodule
`default_nettype wire
